// File: sv/rfc8_pkg.sv
// Package with the types, codes and CRC function of the record framer.
package rfc8_pkg;

	localparam int CMD_W = 2;
	localparam int BYTE_W = 8;
	localparam int WORD_W = 32;
	localparam int LEN_W = 24;
	localparam int STATUS_W = 2;
	localparam int TRAILER_LEN = 2 + 4 * 4;
	localparam int IDX_W = $clog2(TRAILER_LEN);

	localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DATA = 2'd1;
	localparam logic [CMD_W-1:0] CMD_END = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DISABLED = 2'd2;

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
	localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
	localparam logic [BYTE_W-1:0] MARK_LO = 8'h55;
	localparam logic [BYTE_W-1:0] MARK_HI = 8'hAA;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TRAILER_LEN - 1);

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [BYTE_W-1:0] data_byte;
		logic [WORD_W-1:0] record_type;
		logic [WORD_W-1:0] start_sample;
		logic              write_out;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   out_byte;
		logic                byte_valid;
		logic                last;
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   sample_position;
		logic                flush_request;
	} result_t;

	typedef struct packed {
		logic    load;
		result_t res;
	} out_ctl_t;

	function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] v;
		v = crc ^ b;
		for (int i = 0; i < BYTE_W; i++) begin
			if (v[BYTE_W-1]) begin
				v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[BYTE_W-2:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

// File: sv/rfc8_in_if.sv
// Command channel interface of the record framer.
interface rfc8_in_if;
	logic                        valid;
	logic                        ready;
	logic [rfc8_pkg::CMD_W-1:0]  cmd;
	logic [rfc8_pkg::BYTE_W-1:0] data_byte;
	logic [rfc8_pkg::WORD_W-1:0] record_type;
	logic [rfc8_pkg::WORD_W-1:0] start_sample;
	logic                        write_out;

	modport source (output valid, cmd, data_byte, record_type, start_sample, write_out,
		input ready);
	modport sink (input valid, cmd, data_byte, record_type, start_sample, write_out,
		output ready);
endinterface

// File: sv/rfc8_out_if.sv
// Record stream channel interface of the record framer.
interface rfc8_out_if;
	logic                          valid;
	logic                          ready;
	logic [rfc8_pkg::BYTE_W-1:0]   out_byte;
	logic                          byte_valid;
	logic                          last;
	logic [rfc8_pkg::STATUS_W-1:0] status;
	logic [rfc8_pkg::WORD_W-1:0]   sample_position;
	logic                          flush_request;

	modport source (output valid, out_byte, byte_valid, last, status, sample_position,
		flush_request, input ready);
	modport sink (input valid, out_byte, byte_valid, last, status, sample_position,
		flush_request, output ready);
endinterface

// File: sv/rfc8_in_reg.sv
// Input register stage holding the command under work.
module rfc8_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rfc8_pkg::item_t in_item,
	input  logic           consume,
	output logic           valid_s1,
	output rfc8_pkg::item_t item_s1
);
	import rfc8_pkg::*;

	assign in_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end
endmodule

// File: sv/rfc8_framer.sv
// Record state, CRC update and trailer byte selection.
module rfc8_framer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             enabled,
	input  logic             valid_s1,
	input  rfc8_pkg::item_t  item_s1,
	input  logic             can_load,
	output logic             consume,
	output rfc8_pkg::out_ctl_t out_ctl
);
	import rfc8_pkg::*;

	logic              open_q;
	logic [WORD_W-1:0] type_q;
	logic [LEN_W-1:0]  len_q;
	logic [BYTE_W-1:0] crc_q;
	logic [WORD_W-1:0] count_q;
	logic [WORD_W-1:0] sample_q;
	logic [IDX_W-1:0]  idx_q;

	logic [WORD_W-1:0] start_pos;
	logic [WORD_W-1:0] crc_len;
	logic [BYTE_W-1:0] tbyte [TRAILER_LEN];
	logic              emit;
	logic              done;
	logic              fire;
	logic              is_last_trailer;
	result_t           res;

	assign start_pos = sample_q - {{(WORD_W-LEN_W){1'b0}}, len_q};
	assign crc_len = {crc_q, len_q};

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			tbyte[i]      = type_q[i*BYTE_W +: BYTE_W];
			tbyte[4 + i]  = crc_len[i*BYTE_W +: BYTE_W];
			tbyte[8 + i]  = count_q[i*BYTE_W +: BYTE_W];
			tbyte[12 + i] = start_pos[i*BYTE_W +: BYTE_W];
		end
		tbyte[16] = MARK_LO;
		tbyte[17] = MARK_HI;
	end

	assign is_last_trailer = (idx_q == IDX_LAST);

	always_comb begin
		res = '0;
		res.last = 1'b1;
		emit = 1'b1;
		done = 1'b1;
		if (!enabled) begin
			res.status = ST_DISABLED;
		end else begin
			case (item_s1.cmd)
				CMD_BEGIN: begin
					res.status = open_q ? ST_REJECTED : ST_OK;
				end
				CMD_DATA: begin
					res.out_byte = item_s1.data_byte;
					res.byte_valid = 1'b1;
				end
				CMD_END: begin
					res.out_byte = tbyte[idx_q];
					res.byte_valid = 1'b1;
					res.last = is_last_trailer;
					res.sample_position = sample_q;
					res.flush_request = is_last_trailer && item_s1.write_out;
					done = is_last_trailer;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	assign fire = valid_s1 && (can_load || !emit);
	assign consume = fire && done;
	assign out_ctl.load = fire && emit;
	assign out_ctl.res = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= 1'b0;
			type_q   <= '0;
			len_q    <= '0;
			crc_q    <= '0;
			count_q  <= '0;
			sample_q <= '0;
			idx_q    <= '0;
		end else if (fire && enabled) begin
			case (item_s1.cmd)
				CMD_BEGIN: begin
					if (!open_q) begin
						open_q   <= 1'b1;
						type_q   <= item_s1.record_type;
						len_q    <= '0;
						crc_q    <= CRC_INIT;
						sample_q <= item_s1.start_sample;
					end
				end
				CMD_DATA: begin
					len_q    <= len_q + 1'b1;
					crc_q    <= crc8_byte(crc_q, item_s1.data_byte);
					sample_q <= sample_q + 1'b1;
				end
				CMD_END: begin
					if (is_last_trailer) begin
						idx_q   <= '0;
						count_q <= count_q + 1'b1;
						open_q  <= 1'b0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end
endmodule

// File: sv/rfc8_out_reg.sv
// Output register stage driving the record stream channel.
module rfc8_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  rfc8_pkg::out_ctl_t out_ctl,
	output logic               can_load,
	output logic               out_valid,
	input  logic               out_ready,
	output rfc8_pkg::result_t  out_res
);
	import rfc8_pkg::*;

	assign can_load = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (can_load) begin
			out_valid <= out_ctl.load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && out_ctl.load) begin
			out_res <= out_ctl.res;
		end
	end
endmodule

// File: sv/record_framer_crc8_unit.sv
// Top level of the record framer with CRC-8 trailer.
// Commands arrive on in_ch: begin opens a record, a data byte passes through
// and extends the record, end emits an 18-byte trailer with the record CRC.
// Each result leaves on out_ch as one transfer; the final one carries last.
// The enable register is written through cfg_we and cfg_data; write it only
// while idle, which the block does not enforce. Commands pass the input and
// output registers. Begin and data commands can follow one every cycle unless
// the receiver stalls. While enabled, an end command holds the input register
// as the framer steps its trailer byte index; the command channel is not
// ready meanwhile. While enabled, the unused command code gives no result.
// When the receiver stalls, the output register holds its result and the
// command under work waits; a new command is still taken while the held
// result is waiting, as long as the command under work can leave.
// Reset clears the record state and counters and sets writing enabled.
module record_framer_crc8_unit (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_we,
	input  logic  cfg_data,
	rfc8_in_if.sink   in_ch,
	rfc8_out_if.source out_ch
);
	import rfc8_pkg::*;

	logic     enabled_q;
	item_t    in_item;
	item_t    item_s1;
	logic     valid_s1;
	logic     consume;
	logic     can_load;
	out_ctl_t out_ctl;
	result_t  out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b1;
		end else if (cfg_we) begin
			enabled_q <= cfg_data;
		end
	end

	assign in_item.cmd          = in_ch.cmd;
	assign in_item.data_byte    = in_ch.data_byte;
	assign in_item.record_type  = in_ch.record_type;
	assign in_item.start_sample = in_ch.start_sample;
	assign in_item.write_out    = in_ch.write_out;

	rfc8_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.in_item  (in_item),
		.consume  (consume),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rfc8_framer u_framer (
		.clk      (clk),
		.arst_n   (arst_n),
		.enabled  (enabled_q),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.can_load (can_load),
		.consume  (consume),
		.out_ctl  (out_ctl)
	);

	rfc8_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.out_ctl   (out_ctl),
		.can_load  (can_load),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_res   (out_res)
	);

	assign out_ch.out_byte        = out_res.out_byte;
	assign out_ch.byte_valid      = out_res.byte_valid;
	assign out_ch.last            = out_res.last;
	assign out_ch.status          = out_res.status;
	assign out_ch.sample_position = out_res.sample_position;
	assign out_ch.flush_request   = out_res.flush_request;
endmodule

// File: test/record_framer_crc8_unit_test.sv
// Self-checking testbench of the record framer: directed and random command streams against a CRC-8 predictor.
`timescale 1ns / 1ps

module record_framer_crc8_unit_test;
	import rfc8_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_data;

	rfc8_in_if  in_ch ();
	rfc8_out_if out_ch ();

	record_framer_crc8_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	item_t   pending_cmds[$];
	result_t expected_stream[$];
	int      queued_count = 0;
	int      accepted_count = 0;
	int      fail_count = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	logic    in_taken = 1'b0;

	// Predicted framer state.
	logic              writing_on = 1'b1;
	logic              rec_open = 1'b0;
	logic [WORD_W-1:0] rec_type = '0;
	logic [LEN_W-1:0]  rec_len = '0;
	logic [BYTE_W-1:0] rec_crc = '0;
	logic [WORD_W-1:0] rec_count = '0;
	logic [WORD_W-1:0] sample_pos = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [BYTE_W-1:0] crc_fold(input logic [BYTE_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] acc;
		logic              fb;
		acc = crc;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			fb = acc[BYTE_W-1] ^ b[i];
			acc = {acc[BYTE_W-2:0], 1'b0} ^ (fb ? 8'h31 : 8'h00);
		end
		return acc;
	endfunction

	function automatic result_t make_result(input logic [BYTE_W-1:0] b, input logic bv,
			input logic lst, input logic [STATUS_W-1:0] st, input logic [WORD_W-1:0] pos,
			input logic fl);
		result_t r;
		r.out_byte = b;
		r.byte_valid = bv;
		r.last = lst;
		r.status = st;
		r.sample_position = pos;
		r.flush_request = fl;
		return r;
	endfunction

	task automatic frame_command(input item_t it);
		logic [WORD_W-1:0] words[4];
		logic [BYTE_W-1:0] tb;
		logic              lst;
		if (!writing_on) begin
			expected_stream.push_back(make_result('0, 1'b0, 1'b1, ST_DISABLED, '0, 1'b0));
			return;
		end
		case (it.cmd)
			CMD_BEGIN: begin
				if (rec_open) begin
					expected_stream.push_back(make_result('0, 1'b0, 1'b1, ST_REJECTED, '0, 1'b0));
				end else begin
					rec_open = 1'b1;
					rec_type = it.record_type;
					rec_len = '0;
					rec_crc = 8'hFF;
					sample_pos = it.start_sample;
					expected_stream.push_back(make_result('0, 1'b0, 1'b1, ST_OK, '0, 1'b0));
				end
			end
			CMD_DATA: begin
				rec_len = rec_len + 1'b1;
				rec_crc = crc_fold(rec_crc, it.data_byte);
				sample_pos = sample_pos + 1;
				expected_stream.push_back(make_result(it.data_byte, 1'b1, 1'b1, ST_OK, '0, 1'b0));
			end
			CMD_END: begin
				words[0] = rec_type;
				words[1] = {rec_crc, rec_len};
				words[2] = rec_count;
				words[3] = sample_pos - {8'h00, rec_len};
				for (int k = 0; k < TRAILER_LEN; k++) begin
					if (k < 16) begin
						tb = words[k / 4][8 * (k % 4) +: 8];
					end else if (k == 16) begin
						tb = MARK_LO;
					end else begin
						tb = MARK_HI;
					end
					lst = (k == TRAILER_LEN - 1);
					expected_stream.push_back(make_result(tb, 1'b1, lst, ST_OK, sample_pos,
						lst & it.write_out));
				end
				rec_count = rec_count + 1;
				rec_open = 1'b0;
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
			input logic [WORD_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, actual %0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// Driver: one item on the command channel, held until its transfer.
	always @(negedge clk) begin
		item_t nxt;
		if (arst_n) begin
			if (!in_ch.valid || in_taken) begin
				if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_cmds.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.cmd <= nxt.cmd;
					in_ch.data_byte <= nxt.data_byte;
					in_ch.record_type <= nxt.record_type;
					in_ch.start_sample <= nxt.start_sample;
					in_ch.write_out <= nxt.write_out;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: predicts on each command transfer and checks each result transfer.
	always @(posedge clk) begin
		item_t   it;
		result_t exp_r;
		if (arst_n) begin
			if (cfg_we) begin
				writing_on = cfg_data;
			end
			if (in_ch.valid && in_ch.ready) begin
				it.cmd = in_ch.cmd;
				it.data_byte = in_ch.data_byte;
				it.record_type = in_ch.record_type;
				it.start_sample = in_ch.start_sample;
				it.write_out = in_ch.write_out;
				frame_command(it);
				accepted_count++;
			end
			in_taken <= in_ch.valid && in_ch.ready;
			if (out_ch.valid && out_ch.ready) begin
				if (expected_stream.size() == 0) begin
					$error("Unexpected result transfer: out_byte %0h status %0h",
						out_ch.out_byte, out_ch.status);
					fail_count++;
				end else begin
					exp_r = expected_stream.pop_front();
					check_field("out_byte", exp_r.out_byte, out_ch.out_byte);
					check_field("byte_valid", exp_r.byte_valid, out_ch.byte_valid);
					check_field("last", exp_r.last, out_ch.last);
					check_field("status", exp_r.status, out_ch.status);
					check_field("sample_position", exp_r.sample_position,
						out_ch.sample_position);
					check_field("flush_request", exp_r.flush_request, out_ch.flush_request);
				end
			end
		end
	end

	function automatic item_t make_cmd(input logic [CMD_W-1:0] c);
		item_t it;
		it.cmd = c;
		it.data_byte = BYTE_W'($urandom);
		it.record_type = $urandom;
		it.start_sample = $urandom;
		it.write_out = 1'($urandom_range(1));
		return it;
	endfunction

	task automatic push_cmd(input item_t it);
		pending_cmds.push_back(it);
		queued_count++;
	endtask

	task automatic push_data(input logic [BYTE_W-1:0] b);
		item_t it;
		it = make_cmd(CMD_DATA);
		it.data_byte = b;
		push_cmd(it);
	endtask

	task automatic push_begin(input logic [WORD_W-1:0] t, input logic [WORD_W-1:0] s);
		item_t it;
		it = make_cmd(CMD_BEGIN);
		it.record_type = t;
		it.start_sample = s;
		push_cmd(it);
	endtask

	task automatic push_end(input logic wo);
		item_t it;
		it = make_cmd(CMD_END);
		it.write_out = wo;
		push_cmd(it);
	endtask

	// Mostly complete records with random content, the rest stray commands.
	task automatic queue_random(input int n);
		int left;
		int nd;
		left = n;
		while (left > 0) begin
			if ($urandom_range(99) < 80) begin
				nd = $urandom_range(10);
				push_cmd(make_cmd(CMD_BEGIN));
				for (int i = 0; i < nd; i++) begin
					push_cmd(make_cmd(CMD_DATA));
				end
				push_cmd(make_cmd(CMD_END));
				left -= nd + 2;
			end else begin
				push_cmd(make_cmd(CMD_W'($urandom_range(3))));
				left--;
			end
		end
	endtask

	task automatic wait_drained();
		wait (accepted_count == queued_count && expected_stream.size() == 0);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_enable(input logic v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_BEGIN;
		in_ch.data_byte = '0;
		in_ch.record_type = '0;
		in_ch.start_sample = '0;
		in_ch.write_out = 1'b0;
		out_ch.ready = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_begin(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_data(8'h00);
		push_data(8'hFF);
		push_begin(32'h0000_0000, 32'h0000_0000);
		push_data(8'hA5);
		push_end(1'b1);
		push_end(1'b0);
		push_data(8'h3C);
		push_cmd(make_cmd(CMD_UNUSED));
		push_begin(32'h0000_0000, 32'h0000_0000);
		push_end(1'b1);
		push_begin(32'h1234_5678, 32'h8000_0000);
		push_data(8'h01);
		push_data(8'h80);
		push_data(8'h7F);
		push_data(8'hFE);
		push_end(1'b0);
		push_cmd(make_cmd(CMD_UNUSED));
		wait_drained();

		write_enable(1'b0);
		set_idling(13, 13);
		push_cmd(make_cmd(CMD_BEGIN));
		push_cmd(make_cmd(CMD_DATA));
		push_cmd(make_cmd(CMD_END));
		push_cmd(make_cmd(CMD_UNUSED));
		for (int i = 0; i < 8; i++) begin
			push_cmd(make_cmd(CMD_W'($urandom_range(3))));
		end
		wait_drained();
		write_enable(1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: set_idling(0, 0);
				1: set_idling(78, 0);
				2: set_idling(0, 78);
				default: set_idling(13, 13);
			endcase
			queue_random(42);
			wait_drained();
			queue_random(42);
			wait_drained();
			if (ph == 1) begin
				write_enable(1'b0);
				for (int i = 0; i < 6; i++) begin
					push_cmd(make_cmd(CMD_W'($urandom_range(3))));
				end
				wait_drained();
				write_enable(1'b1);
			end
		end

		if (expected_stream.size() != 0) begin
			$error("%0d expected results never arrived", expected_stream.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("** record_framer_crc8_unit: PASSED **");
		end else begin
			$display("** record_framer_crc8_unit: FAILED **");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("** record_framer_crc8_unit: FAILED **");
		$finish;
	end

endmodule
